// ===== rtl/core/cch_pkg.sv =====
// ----------------------------------------------------------------------------
// cch_pkg: shared types and constants of the compass heading pipeline
// Widths, fixed-point formats, the arctangent table and the stage map.
// ----------------------------------------------------------------------------
package cch_pkg;

	// Iteration count and calibration scale format
	localparam int CORDIC_ITERATIONS = 16;
	localparam int SCALE_FRAC_BITS   = 14;
	localparam int TABLE_LEN         = 24;
	localparam int NUM_ITER = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;

	// Field and register widths
	localparam int RAW_W     = 16;
	localparam int OFF_W     = 12;
	localparam int SCALE_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CENT_W    = 16;

	// Calibration datapath
	localparam int SUM_W  = RAW_W + 1;
	localparam int MAG_W  = RAW_W;
	localparam int PROD_W = MAG_W + SCALE_W;
	localparam int CAL_W  = PROD_W - SCALE_FRAC_BITS;

	// Rotation vector: calibrated magnitude shifted up, plus growth and sign
	localparam int VEC_SHIFT = 20;
	localparam int VEC_W     = CAL_W + VEC_SHIFT + 3;

	// Angle: degrees scaled by 2^ANG_FRAC
	localparam int ANG_FRAC = 22;
	localparam int Z_W      = 33;
	localparam int ANG_W    = 31;
	localparam int ATAN_W   = 28;
	localparam int MUL_W    = 7;
	localparam int MPROD_W  = ANG_W + MUL_W;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [Z_W-1:0]   ang_t;

	localparam ang_t DEG90  = ang_t'(longint'(90)  <<< ANG_FRAC);
	localparam ang_t DEG270 = ang_t'(longint'(270) <<< ANG_FRAC);
	localparam ang_t DEG360 = ang_t'(longint'(360) <<< ANG_FRAC);

	// atan(2^-i) in degrees * 2^ANG_FRAC, rounded to nearest
	localparam logic [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485,
		28'd15000234,  28'd7507429,   28'd3754631,  28'd1877430,
		28'd938729,    28'd469366,    28'd234683,   28'd117342,
		28'd58671,     28'd29335,     28'd14668,    28'd7334,
		28'd3667,      28'd1833,      28'd917,      28'd458,
		28'd229,       28'd115,       28'd57,       28'd29
	};

	// Output scaling and special bearings
	localparam logic [MUL_W-1:0]   CENT_PER_DEG = 7'd100;
	localparam logic [MPROD_W-1:0] ROUND_HALF   = MPROD_W'(1) << (ANG_FRAC - 1);
	localparam logic [CENT_W-1:0]  CENT_FULL    = 16'd36000;
	localparam logic [CENT_W-1:0]  CENT_NULL    = 16'd9000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 2'd3;

	// Register reset values
	localparam logic signed [OFF_W-1:0] X_OFFSET_RST = -12'sd7;
	localparam logic signed [OFF_W-1:0] Y_OFFSET_RST = 12'sd54;
	localparam logic [SCALE_W-1:0]      X_SCALE_RST  = 16'd17531;
	localparam logic [SCALE_W-1:0]      Y_SCALE_RST  = 16'd18301;

	// Stage map of the pipeline
	localparam int ST_S1   = 0;
	localparam int ST_S2   = 1;
	localparam int ST_S3   = 2;
	localparam int ST_COR  = 3;
	localparam int ST_WRAP = ST_COR + NUM_ITER;
	localparam int ST_MUL  = ST_WRAP + 1;
	localparam int ST_OUT  = ST_MUL + 1;
	localparam int NUM_STG = ST_OUT + 1;

endpackage

// ===== rtl/core/cch_cordic.sv =====
// ----------------------------------------------------------------------------
// cch_cordic: pipelined CORDIC vectoring unit
// One micro-rotation per register stage; each stage loads on its own enable.
// ----------------------------------------------------------------------------
module cch_cordic (
	input  logic                          clk,
	input  logic [cch_pkg::NUM_ITER-1:0]  en,
	input  cch_pkg::vec_t                 x_in,
	input  cch_pkg::vec_t                 y_in,
	input  cch_pkg::ang_t                 z_in,
	input  logic                          zero_in,
	output cch_pkg::ang_t                 z_out,
	output logic                          zero_out
);
	import cch_pkg::*;

	vec_t x_s [NUM_ITER-1];
	vec_t y_s [NUM_ITER-1];
	ang_t z_s [NUM_ITER];
	logic zero_s [NUM_ITER];

	for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
		vec_t xi;
		vec_t yi;
		ang_t zi;
		logic fi;
		ang_t da;

		// Pick stage input
		if (i == 0) begin : g_first
			assign xi = x_in;
			assign yi = y_in;
			assign zi = z_in;
			assign fi = zero_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign fi = zero_s[i-1];
		end

		assign da = ang_t'(ATAN_TAB[i]);

		// Rotate angle toward zero residual y
		always_ff @(posedge clk) begin
			if (en[i]) begin
				z_s[i]    <= yi[VEC_W-1] ? (zi - da) : (zi + da);
				zero_s[i] <= fi;
			end
		end

		// Rotate vector; the last stage needs only the angle
		if (i < NUM_ITER - 1) begin : g_xy
			always_ff @(posedge clk) begin
				if (en[i]) begin
					if (!yi[VEC_W-1]) begin
						x_s[i] <= xi + (yi >>> i);
						y_s[i] <= yi - (xi >>> i);
					end else begin
						x_s[i] <= xi - (yi >>> i);
						y_s[i] <= yi + (xi >>> i);
					end
				end
			end
		end
	end

	assign z_out    = z_s[NUM_ITER-1];
	assign zero_out = zero_s[NUM_ITER-1];

endmodule

// ===== rtl/core/calibrated_compass_heading.sv =====
// ----------------------------------------------------------------------------
// calibrated_compass_heading: compass bearing from a calibrated X/Y sample
// Each pipeline stage is one register.
// Throughput: one request per cycle unless stalled; the CORDIC pipeline has one
// stage per iteration, and a stalled output lets empty stages upstream keep filling.
// Reset clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module calibrated_compass_heading (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [cch_pkg::RAW_W-1:0]     x_raw,
	input  logic signed [cch_pkg::RAW_W-1:0]     y_raw,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [cch_pkg::CENT_W-1:0]           heading_centideg,
	input  logic                                 cfg_wr_en,
	input  logic [cch_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cch_pkg::CFG_W-1:0]            cfg_data
);
	import cch_pkg::*;

	// Calibration registers
	logic signed [OFF_W-1:0] x_offset_q, y_offset_q;
	logic [SCALE_W-1:0]      x_scale_q, y_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= X_OFFSET_RST;
			y_offset_q <= Y_OFFSET_RST;
			x_scale_q  <= X_SCALE_RST;
			y_scale_q  <= Y_SCALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_X_OFFSET: x_offset_q <= cfg_data[OFF_W-1:0];
				REG_Y_OFFSET: y_offset_q <= cfg_data[OFF_W-1:0];
				REG_X_SCALE:  x_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_Y_SCALE:  y_scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valid bits and load enables; a stage loads when empty or moving on
	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG:0]   adv;

	always_comb begin
		adv[NUM_STG] = !out_stall;
		for (int k = NUM_STG - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[NUM_STG-1];

	// Stage 1: add offsets, split into sign and magnitude
	logic signed [SUM_W-1:0] x_sum, y_sum;
	logic [MAG_W-1:0]        x_mag_s1, y_mag_s1;
	logic                    x_neg_s1, y_neg_s1;

	assign x_sum = SUM_W'(x_raw) + SUM_W'(x_offset_q);
	assign y_sum = SUM_W'(y_raw) + SUM_W'(y_offset_q);

	always_ff @(posedge clk) begin
		if (adv[ST_S1]) begin
			x_neg_s1 <= x_sum[SUM_W-1];
			y_neg_s1 <= y_sum[SUM_W-1];
			x_mag_s1 <= x_sum[SUM_W-1] ? MAG_W'(-x_sum) : MAG_W'(x_sum);
			y_mag_s1 <= y_sum[SUM_W-1] ? MAG_W'(-y_sum) : MAG_W'(y_sum);
		end
	end

	// Stage 2: apply soft-iron scale
	logic [PROD_W-1:0] x_prod_s2, y_prod_s2;
	logic              x_neg_s2, y_neg_s2;

	always_ff @(posedge clk) begin
		if (adv[ST_S2]) begin
			x_neg_s2  <= x_neg_s1;
			y_neg_s2  <= y_neg_s1;
			x_prod_s2 <= PROD_W'(x_mag_s1) * PROD_W'(x_scale_q);
			y_prod_s2 <= PROD_W'(y_mag_s1) * PROD_W'(y_scale_q);
		end
	end

	// Stage 3: truncate, fold left half-plane onto the right, seed the angle
	logic [CAL_W-1:0] x_cal, y_cal;
	logic             x_left, y_flip;
	vec_t             x_vec, y_mvec;
	vec_t             x_s3, y_s3;
	ang_t             z_s3;
	logic             zero_s3;

	assign x_cal  = x_prod_s2[PROD_W-1:SCALE_FRAC_BITS];
	assign y_cal  = y_prod_s2[PROD_W-1:SCALE_FRAC_BITS];
	assign x_left = x_neg_s2 && (x_cal != '0);
	assign y_flip = y_neg_s2 ^ x_left;
	assign x_vec  = vec_t'({x_cal, {VEC_SHIFT{1'b0}}});
	assign y_mvec = vec_t'({y_cal, {VEC_SHIFT{1'b0}}});

	always_ff @(posedge clk) begin
		if (adv[ST_S3]) begin
			x_s3    <= x_vec;
			y_s3    <= y_flip ? -y_mvec : y_mvec;
			z_s3    <= x_left ? DEG270 : DEG90;
			zero_s3 <= (x_cal == '0) && (y_cal == '0);
		end
	end

	// CORDIC stages
	ang_t z_cor;
	logic zero_cor;

	cch_cordic u_cordic (
		.clk      (clk),
		.en       (adv[ST_COR +: NUM_ITER]),
		.x_in     (x_s3),
		.y_in     (y_s3),
		.z_in     (z_s3),
		.zero_in  (zero_s3),
		.z_out    (z_cor),
		.zero_out (zero_cor)
	);

	// Wrap stage: fold the angle into [0, 360)
	ang_t             z_wrap;
	logic [ANG_W-1:0] z_wrap_s4;
	logic             zero_s4;

	always_comb begin
		if (z_cor < 0) begin
			z_wrap = z_cor + DEG360;
		end else if (z_cor >= DEG360) begin
			z_wrap = z_cor - DEG360;
		end else begin
			z_wrap = z_cor;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_WRAP]) begin
			z_wrap_s4 <= z_wrap[ANG_W-1:0];
			zero_s4   <= zero_cor;
		end
	end

	// Scale stage: hundredths of a degree, plus rounding half
	logic [MPROD_W-1:0] z_scl_s5;
	logic               zero_s5;

	always_ff @(posedge clk) begin
		if (adv[ST_MUL]) begin
			z_scl_s5 <= MPROD_W'(z_wrap_s4) * MPROD_W'(CENT_PER_DEG) + ROUND_HALF;
			zero_s5  <= zero_s4;
		end
	end

	// Output stage: drop fraction, map full turn to zero, null vector to 9000
	logic [CENT_W-1:0] cent;
	logic [CENT_W-1:0] head_s6;

	assign cent = z_scl_s5[ANG_FRAC +: CENT_W];

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			if (zero_s5) begin
				head_s6 <= CENT_NULL;
			end else if (cent >= CENT_FULL) begin
				head_s6 <= '0;
			end else begin
				head_s6 <= cent;
			end
		end
	end

	assign heading_centideg = head_s6;

endmodule

// ===== tb/sv/cch_heading_checker.sv =====
// ----------------------------------------------------------------------------
// cch_heading_checker: bearing predictor and scoreboard for the compass block
// Watches the sample, bearing and register ports. On each accepted sample it
// predicts the bearing from its own copy of the calibration registers and
// queues it. Each accepted bearing is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module cch_heading_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [cch_pkg::RAW_W-1:0]     x_raw,
	input  logic signed [cch_pkg::RAW_W-1:0]     y_raw,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [cch_pkg::CENT_W-1:0]           heading_centideg,
	input  logic                                 cfg_wr_en,
	input  logic [cch_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cch_pkg::CFG_W-1:0]            cfg_data,
	output int                                   fail_count,
	output int                                   pending
);

	localparam int ITERS      = 16;
	localparam int SCALE_FRAC = 14;
	localparam int ANGLE_FRAC = 22;
	localparam int VEC_UP     = 20;
	localparam longint RIGHT_ANGLE  = longint'(90) <<< ANGLE_FRAC;
	localparam longint STRAIGHT     = longint'(180) <<< ANGLE_FRAC;
	localparam longint FULL_TURN    = longint'(360) <<< ANGLE_FRAC;
	localparam longint CENT_WRAP    = 36000;
	localparam logic [15:0] BEARING_NULL = 16'd9000;

	// atan(2^-i) in degrees scaled by 2^22
	localparam longint ARCTAN_FX [24] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
		3754631, 1877430, 938729, 469366, 234683, 117342,
		58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29
	};

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        bearing;
	} bearing_t;

	bearing_t           expected_headings [$];
	bearing_t           oldest;
	logic signed [11:0] x_off;
	logic signed [11:0] y_off;
	logic [15:0]        x_scl;
	logic [15:0]        y_scl;
	int                 fails   = 0;
	int                 waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	// offset, scale, truncate toward zero
	function automatic longint scale_axis(logic signed [15:0] raw, logic signed [11:0] off,
			logic [15:0] scl);
		longint sum;
		longint mag;
		longint prod;
		sum  = longint'(raw) + longint'(off);
		mag  = (sum < 0) ? -sum : sum;
		prod = (mag * longint'(scl)) >>> SCALE_FRAC;
		return (sum < 0) ? -prod : prod;
	endfunction

	function automatic logic [15:0] predict_heading(logic signed [15:0] xr, logic signed [15:0] yr);
		longint xv;
		longint yv;
		longint dx;
		longint dy;
		longint ang;
		longint cent;
		xv = scale_axis(xr, x_off, x_scl);
		yv = scale_axis(yr, y_off, y_scl);
		if (xv == 0 && yv == 0)
			return BEARING_NULL;
		ang = RIGHT_ANGLE;
		// fold the left half-plane over to the right
		if (xv < 0) begin
			xv  = -xv;
			yv  = -yv;
			ang = ang + STRAIGHT;
		end
		xv = xv <<< VEC_UP;
		yv = yv <<< VEC_UP;
		// rotate the vector onto the X axis, accumulating the angle
		for (int i = 0; i < ITERS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv  = xv + dx;
				yv  = yv - dy;
				ang = ang + ARCTAN_FX[i];
			end else begin
				xv  = xv - dx;
				yv  = yv + dy;
				ang = ang - ARCTAN_FX[i];
			end
		end
		if (ang < 0)
			ang = ang + FULL_TURN;
		if (ang >= FULL_TURN)
			ang = ang - FULL_TURN;
		cent = (ang * 100 + (longint'(1) <<< (ANGLE_FRAC - 1))) >>> ANGLE_FRAC;
		if (cent >= CENT_WRAP)
			cent = 0;
		return cent[15:0];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: bearing error: %s, got %0d, predicted %0d", $time, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off = -12'sd7;
			y_off = 12'sd54;
			x_scl = 16'd17531;
			y_scl = 16'd18301;
			expected_headings.delete();
			waiting = 0;
		end else begin
			// match a delivered bearing against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_headings.size() == 0) begin
					report_mismatch("bearing with no request outstanding", heading_centideg, -1);
				end else begin
					oldest = expected_headings.pop_front();
					if (heading_centideg !== oldest.bearing)
						report_mismatch($sformatf("sample x=%0d y=%0d", oldest.x, oldest.y),
							heading_centideg, oldest.bearing);
				end
			end
			// predict each accepted request
			if (in_valid && !in_stall)
				expected_headings.push_back('{x_raw, y_raw, predict_heading(x_raw, y_raw)});
			// track register writes
			if (cfg_wr_en) begin
				case (cfg_index)
					cch_pkg::REG_X_OFFSET: x_off = cfg_data[11:0];
					cch_pkg::REG_Y_OFFSET: y_off = cfg_data[11:0];
					cch_pkg::REG_X_SCALE:  x_scl = cfg_data;
					cch_pkg::REG_Y_SCALE:  y_scl = cfg_data;
					default: ;
				endcase
			end
			waiting = expected_headings.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the calibrated compass heading block
// Runs directed corner samples, then phases of random samples under several
// calibration settings with random idle gaps and output stalls, one long
// output hold-off and full drains. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int HOLD_CYCLES = 120;
	localparam int NUM_PHASES  = 9;
	localparam int TAIL_CYCLES = 40;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic signed [cch_pkg::RAW_W-1:0]   x_raw;
	logic signed [cch_pkg::RAW_W-1:0]   y_raw;
	logic                               out_valid;
	logic                               out_stall;
	logic [cch_pkg::CENT_W-1:0]         heading_centideg;
	logic                               cfg_wr_en;
	logic [cch_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [cch_pkg::CFG_W-1:0]          cfg_data;
	int                                 fail_count;
	int                                 pending;
	bit                                 no_idle  = 1'b0;
	bit                                 hold_req = 1'b0;
	logic signed [11:0]                 cur_xo   = -12'sd7;
	logic signed [11:0]                 cur_yo   = 12'sd54;

	calibrated_compass_heading uut (.*);

	cch_heading_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// give up on a hung run
	initial begin
		#6_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic int sender_gap();
		if (no_idle || $urandom_range(0, 1) == 0)
			return 0;
		return gap_len();
	endfunction

	// full range, extremes, or a value that nearly cancels the offset
	function automatic logic signed [15:0] rand_axis(logic signed [11:0] off);
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			1, 2: return 16'(int'($urandom_range(0, 80)) - 40 - int'(off));
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one request and hold it until accepted
	task automatic send_sample(input logic signed [15:0] xs, input logic signed [15:0] ys,
			input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		x_raw    <= xs;
		y_raw    <= ys;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and wait for every outstanding bearing
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cch_pkg::CFG_IDX_W-1:0] idx,
			input logic [cch_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// load all four registers; junk in the unused offset bits
	task automatic set_config(input logic signed [11:0] xo, input logic signed [11:0] yo,
			input logic [15:0] xs, input logic [15:0] ys);
		cur_xo = xo;
		cur_yo = yo;
		write_reg(cch_pkg::REG_X_OFFSET, {4'($urandom), xo});
		write_reg(cch_pkg::REG_Y_OFFSET, {4'($urandom), yo});
		write_reg(cch_pkg::REG_X_SCALE, xs);
		write_reg(cch_pkg::REG_Y_SCALE, ys);
	endtask

	// output side: random stalls, or one long hold-off on request
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0)
					stall_left = gap_len();
				out_stall <= (stall_left != 0);
				if (stall_left != 0)
					stall_left--;
			end
		end
	end

	initial begin
		int n;
		int gap;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		x_raw     = '0;
		y_raw     = '0;
		cfg_wr_en = 1'b0;
		cfg_index = cch_pkg::REG_X_OFFSET;
		cfg_data  = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// corners under the reset calibration (x offset -7, y offset 54)
		send_sample(16'sd7, -16'sd54, sender_gap());        // both axes zero
		send_sample(16'sh7FFF, 16'sh7FFF, sender_gap());
		send_sample(16'sh8000, 16'sh8000, sender_gap());
		send_sample(16'sh7FFF, 16'sh8000, sender_gap());
		send_sample(16'sh8000, 16'sh7FFF, sender_gap());
		send_sample(16'sd7, 16'sh7FFF, sender_gap());       // on the Y axis
		send_sample(16'sd7, 16'sh8000, sender_gap());
		send_sample(16'sh7FFF, -16'sd54, sender_gap());     // on the X axis
		send_sample(16'sh8000, -16'sd54, sender_gap());
		send_sample(16'sd6, 16'sh8000, sender_gap());       // rounds up to a full turn
		send_sample(16'sd8, 16'sh8000, sender_gap());
		send_sample(16'sd6, 16'sh7FFF, sender_gap());
		send_sample(16'sd8, 16'sh7FFF, sender_gap());
		send_sample(16'sd0, 16'sd0, sender_gap());
		send_sample(-16'sd1, -16'sd1, sender_gap());
		send_sample(16'sd1000, -16'sd1000, sender_gap());
		send_sample(-16'sd1000, 16'sd1000, sender_gap());

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph)
				0: set_config(12'sh7FF, 12'sh800, 16'hFFFF, 16'hFFFF);
				1: set_config(12'sh800, 12'sh7FF, 16'h4000, 16'h4000);
				2: set_config(12'sh000, 12'sh000, 16'h0000, 16'h0000);
				4: set_config(12'sh000, 12'sh800, 16'hFFFF, 16'h0000);
				default: set_config(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
			endcase
			n       = (ph == 2) ? 20 : 200;
			no_idle = (ph == 3 || ph == 6);
			for (int k = 0; k < n; k++) begin
				// hold the output off while requests keep coming back to back
				if (ph == 1 && k == 40)
					hold_req = 1'b1;
				// let everything drain mid-phase
				if (ph == 4 && k == 100)
					drain();
				gap = (ph == 1 && k >= 40 && k < 160) ? 0 : sender_gap();
				send_sample(rand_axis(cur_xo), rand_axis(cur_yo), gap);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/cch_pkg.sv
rtl/core/cch_cordic.sv
rtl/core/calibrated_compass_heading.sv
tb/sv/cch_heading_checker.sv
tb/sv/tb_top.sv
